/* hw/rtl/flq_pkg.sv */
// Package for the fix lock qualifier: register map, reset values,
// configuration and result types. No dependencies.
`default_nettype none

package flq_pkg;

    localparam int unsigned TimeW  = 32;
    localparam int unsigned RegW   = 27;
    localparam int unsigned NumRegs = 5;
    localparam int unsigned IdxW   = 3;

    typedef enum logic [IdxW-1:0] {
        REG_LOCK_HOLD      = 3'd0,
        REG_UNLOCK_HOLD    = 3'd1,
        REG_BLINK_INTERVAL = 3'd2,
        REG_BLINK_PULSE    = 3'd3,
        REG_NOTICE_INTERVAL = 3'd4
    } reg_idx_t;

    localparam logic [RegW-1:0] LockHoldRst       = 27'd3000;
    localparam logic [RegW-1:0] UnlockHoldRst     = 27'd10000;
    localparam logic [RegW-1:0] BlinkIntervalRst  = 27'd2000;
    localparam logic [RegW-1:0] BlinkPulseRst     = 27'd100;
    localparam logic [RegW-1:0] NoticeIntervalRst = 27'd10000;

    typedef struct packed {
        logic [RegW-1:0] lock_hold_ms;
        logic [RegW-1:0] unlock_hold_ms;
        logic [RegW-1:0] blink_interval_ms;
        logic [RegW-1:0] blink_pulse_ms;
        logic [RegW-1:0] notice_interval_ms;
    } cfg_t;

    typedef struct packed {
        logic led_level;
        logic locked;
        logic lock_gained;
        logic lock_dropped;
        logic no_fix_notice;
        logic fix_echo;
    } res_t;

endpackage

`default_nettype wire

/* hw/rtl/flq_if.sv */
// Valid/ready channel interfaces for samples and results.
// Depends on flq_pkg for the timestamp width.
`default_nettype none

interface flq_sample_if;
    logic                        valid;
    logic                        ready;
    logic [flq_pkg::TimeW-1:0]   now_ms;
    logic                        has_fix;

    modport source (output valid, output now_ms, output has_fix, input ready);
    modport sink   (input valid, input now_ms, input has_fix, output ready);
endinterface

interface flq_result_if;
    logic valid;
    logic ready;
    logic led_level;
    logic locked;
    logic lock_gained;
    logic lock_dropped;
    logic no_fix_notice;
    logic fix_echo;

    modport source (output valid, output led_level, output locked, output lock_gained,
                    output lock_dropped, output no_fix_notice, output fix_echo,
                    input ready);
    modport sink   (input valid, input led_level, input locked, input lock_gained,
                    input lock_dropped, input no_fix_notice, input fix_echo,
                    output ready);
endinterface

`default_nettype wire

/* hw/rtl/flq_cfg_regs.sv */
// Configuration register file: five 27-bit millisecond settings.
// Depends on flq_pkg.
`default_nettype none

module flq_cfg_regs (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [flq_pkg::IdxW-1:0]  cfg_index,
    input  wire logic [flq_pkg::RegW-1:0]  cfg_wdata,
    output flq_pkg::cfg_t                  cfg
);

    flq_pkg::cfg_t cfg_reg;
    flq_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                flq_pkg::REG_LOCK_HOLD:       cfg_next.lock_hold_ms       = cfg_wdata;
                flq_pkg::REG_UNLOCK_HOLD:     cfg_next.unlock_hold_ms     = cfg_wdata;
                flq_pkg::REG_BLINK_INTERVAL:  cfg_next.blink_interval_ms  = cfg_wdata;
                flq_pkg::REG_BLINK_PULSE:     cfg_next.blink_pulse_ms     = cfg_wdata;
                flq_pkg::REG_NOTICE_INTERVAL: cfg_next.notice_interval_ms = cfg_wdata;
                default: ; // unmapped index, write dropped
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lock_hold_ms       <= flq_pkg::LockHoldRst;
            cfg_reg.unlock_hold_ms     <= flq_pkg::UnlockHoldRst;
            cfg_reg.blink_interval_ms  <= flq_pkg::BlinkIntervalRst;
            cfg_reg.blink_pulse_ms     <= flq_pkg::BlinkPulseRst;
            cfg_reg.notice_interval_ms <= flq_pkg::NoticeIntervalRst;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* hw/rtl/flq_core.sv */
// Lock qualifier state and per-sample update: hold timers, blink timer,
// notice timer. One sample is processed per step. Depends on flq_pkg.
`default_nettype none

module flq_core (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       step,
    input  wire logic [flq_pkg::TimeW-1:0]  now_ms,
    input  wire logic                       has_fix,
    input  wire flq_pkg::cfg_t              cfg,
    output flq_pkg::res_t                   res
);

    logic                      lock_flag_reg,        lock_flag_next;
    logic [flq_pkg::TimeW-1:0] fix_start_reg,        fix_start_next;
    logic                      fix_start_valid_reg,  fix_start_valid_next;
    logic [flq_pkg::TimeW-1:0] loss_start_reg,       loss_start_next;
    logic                      loss_start_valid_reg, loss_start_valid_next;
    logic [flq_pkg::TimeW-1:0] blink_start_reg,      blink_start_next;
    logic                      blink_due_reg,        blink_due_next;
    logic [flq_pkg::TimeW-1:0] pulse_end_reg,        pulse_end_next;
    logic [flq_pkg::TimeW-1:0] last_notice_reg,      last_notice_next;
    logic                      led_reg,              led_next;

    logic [flq_pkg::TimeW-1:0] fix_elapsed;
    logic [flq_pkg::TimeW-1:0] loss_elapsed;
    logic [flq_pkg::TimeW-1:0] blink_elapsed;
    logic [flq_pkg::TimeW-1:0] notice_elapsed;
    logic                      hold_met;
    logic                      unhold_met;
    logic                      gained;
    logic                      dropped;
    logic                      notice;

    // a fresh start timestamp is "now", so its elapsed time is zero
    assign fix_elapsed    = fix_start_valid_reg  ? (now_ms - fix_start_reg)  : '0;
    assign loss_elapsed   = loss_start_valid_reg ? (now_ms - loss_start_reg) : '0;
    assign blink_elapsed  = now_ms - blink_start_reg;
    assign notice_elapsed = now_ms - last_notice_reg;

    assign hold_met   = fix_elapsed  >= {{(flq_pkg::TimeW-flq_pkg::RegW){1'b0}}, cfg.lock_hold_ms};
    assign unhold_met = loss_elapsed >= {{(flq_pkg::TimeW-flq_pkg::RegW){1'b0}},
                                         cfg.unlock_hold_ms};

    always_comb
    begin
        lock_flag_next        = lock_flag_reg;
        fix_start_next        = fix_start_reg;
        fix_start_valid_next  = fix_start_valid_reg;
        loss_start_next       = loss_start_reg;
        loss_start_valid_next = loss_start_valid_reg;
        blink_start_next      = blink_start_reg;
        blink_due_next        = blink_due_reg;
        pulse_end_next        = pulse_end_reg;
        last_notice_next      = last_notice_reg;
        led_next              = led_reg;
        gained                = 1'b0;
        dropped               = 1'b0;
        notice                = 1'b0;

        if (has_fix)
        begin
            loss_start_valid_next = 1'b0;
            fix_start_valid_next  = 1'b0;
            if (!lock_flag_reg)
            begin
                if (!fix_start_valid_reg)
                begin
                    fix_start_next = now_ms;
                end
                if (hold_met)
                begin
                    lock_flag_next = 1'b1;
                    gained         = 1'b1;
                end
                else
                begin
                    fix_start_valid_next = 1'b1;
                end
            end
        end
        else
        begin
            fix_start_valid_next  = 1'b0;
            loss_start_valid_next = 1'b1;
            if (!loss_start_valid_reg)
            begin
                loss_start_next = now_ms;
            end
            if (lock_flag_reg && unhold_met)
            begin
                lock_flag_next = 1'b0;
                blink_due_next = 1'b1;
                pulse_end_next = '0;
                dropped        = 1'b1;
            end
        end

        if (lock_flag_next)
        begin
            led_next = 1'b1;
        end
        else if (blink_due_next ||
                 blink_elapsed >= {{(flq_pkg::TimeW-flq_pkg::RegW){1'b0}},
                                   cfg.blink_interval_ms})
        begin
            blink_due_next   = 1'b0;
            blink_start_next = now_ms;
            pulse_end_next   = now_ms + {{(flq_pkg::TimeW-flq_pkg::RegW){1'b0}},
                                         cfg.blink_pulse_ms};
            led_next         = 1'b1;
        end
        else if (now_ms >= pulse_end_next)
        begin
            led_next = 1'b0;
        end

        if (!has_fix &&
            notice_elapsed >= {{(flq_pkg::TimeW-flq_pkg::RegW){1'b0}},
                               cfg.notice_interval_ms})
        begin
            last_notice_next = now_ms;
            notice           = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lock_flag_reg        <= 1'b0;
            fix_start_reg        <= '0;
            fix_start_valid_reg  <= 1'b0;
            loss_start_reg       <= '0;
            loss_start_valid_reg <= 1'b0;
            blink_start_reg      <= '0;
            blink_due_reg        <= 1'b1;
            pulse_end_reg        <= '0;
            last_notice_reg      <= '0;
            led_reg              <= 1'b0;
        end
        else if (step)
        begin
            lock_flag_reg        <= lock_flag_next;
            fix_start_reg        <= fix_start_next;
            fix_start_valid_reg  <= fix_start_valid_next;
            loss_start_reg       <= loss_start_next;
            loss_start_valid_reg <= loss_start_valid_next;
            blink_start_reg      <= blink_start_next;
            blink_due_reg        <= blink_due_next;
            pulse_end_reg        <= pulse_end_next;
            last_notice_reg      <= last_notice_next;
            led_reg              <= led_next;
        end
    end

    assign res.led_level     = led_next;
    assign res.locked        = lock_flag_next;
    assign res.lock_gained   = gained;
    assign res.lock_dropped  = dropped;
    assign res.no_fix_notice = notice;
    assign res.fix_echo      = has_fix;

    a_gain_sets_lock: assert property (@(posedge clk) disable iff (!rst_n)
        step && gained |=> lock_flag_reg)
        else $error("lock not held after gain");

    a_drop_starts_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        step && dropped |=> led_reg && !lock_flag_reg && !blink_due_reg)
        else $error("drop did not start a pulse");

    a_gain_drop_excl: assert property (@(posedge clk) disable iff (!rst_n)
        step |-> !(gained && dropped))
        else $error("gain and drop on one sample");

    a_locked_led_on: assert property (@(posedge clk) disable iff (!rst_n)
        lock_flag_reg |-> led_reg)
        else $error("LED off while locked");

endmodule

`default_nettype wire

/* hw/rtl/fix_lock_qualifier_with_blink.sv */
// Fix lock qualifier with blink indicator, top level.
// Uses flq_pkg, flq_if, flq_cfg_regs and flq_core.
//
// Usage:
//   sample: valid/ready channel of {now_ms, has_fix}, one sample per item.
//   result: valid/ready channel of {led_level, locked, lock_gained,
//           lock_dropped, no_fix_notice, fix_echo}, exactly one per sample.
//   cfg_we/cfg_index/cfg_wdata: register writes, taken on any edge with
//           cfg_we high; indexes above 4 are ignored. Write only while idle.
// Path: an accepted sample is held in the input register, evaluated
//   against the lock state when it advances, and its result is loaded
//   into the output register, from which it is offered on result.
// Throughput: one sample per clock while the result side keeps up. The
//   combinational state update (32-bit subtract and compare on the hold, blink
//   and notice timers) sets the clock period.
// Reset: all timers cleared, unlocked, LED off, first unlocked sample
//   starts a pulse; registers return to their defaults.
// Stall: the input register and output register each hold one item;
//   with the result stalled the block takes one more sample, then
//   deasserts sample.ready until the result is taken.
`default_nettype none

module fix_lock_qualifier_with_blink (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    flq_sample_if.sink                     sample,
    flq_result_if.source                   result,
    input  wire logic                      cfg_we,
    input  wire logic [flq_pkg::IdxW-1:0]  cfg_index,
    input  wire logic [flq_pkg::RegW-1:0]  cfg_wdata
);

    flq_pkg::cfg_t cfg;
    flq_pkg::res_t core_res;

    logic                      in_valid_reg;
    logic [flq_pkg::TimeW-1:0] in_now_reg;
    logic                      in_fix_reg;
    logic                      out_valid_reg;
    flq_pkg::res_t             out_res_reg;
    logic                      advance;
    logic                      take;

    assign advance      = in_valid_reg && (!out_valid_reg || result.ready);
    assign sample.ready = !in_valid_reg || advance;
    assign take         = sample.valid && sample.ready;

    flq_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    flq_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .now_ms  (in_now_reg),
        .has_fix (in_fix_reg),
        .cfg     (cfg),
        .res     (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (sample.ready)
            begin
                in_valid_reg <= sample.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_now_reg <= sample.now_ms;
            in_fix_reg <= sample.has_fix;
        end
        if (advance)
        begin
            out_res_reg <= core_res;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.led_level     = out_res_reg.led_level;
    assign result.locked        = out_res_reg.locked;
    assign result.lock_gained   = out_res_reg.lock_gained;
    assign result.lock_dropped  = out_res_reg.lock_dropped;
    assign result.no_fix_notice = out_res_reg.no_fix_notice;
    assign result.fix_echo      = out_res_reg.fix_echo;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result.ready |-> !advance)
        else $error("pending result overwritten");

    a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("result register not loaded");

    a_held_input_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |-> !sample.ready)
        else $error("input register overrun");

endmodule

`default_nettype wire

/* sim/fix_lock_qualifier_with_blink_tb.sv */
// Self-checking bench for fix_lock_qualifier_with_blink: directed bring-up rows,
// then random timestamp/fix runs under several register settings and flow-control mixes.
// Depends on flq_pkg, flq_if and the block's RTL.

module fix_lock_qualifier_with_blink_tb;

    import flq_pkg::*;

    typedef enum logic {
        ROW_SAMPLE,
        ROW_REG
    } row_kind_e;

    typedef enum int {
        CFG_RANDOM,
        CFG_ZERO,
        CFG_MAX
    } cfg_mode_e;

    typedef struct packed {
        row_kind_e          kind;
        logic [IdxW-1:0]    idx;
        logic [RegW-1:0]    val;
        logic [TimeW-1:0]   t;
        logic               fix;
        logic               typed;
        res_t               want;
    } bringup_row_t;

    localparam logic [IdxW-1:0] IdxUnused = 3'd7;
    localparam logic [RegW-1:0] MsMax     = 27'd86400000;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                smp_valid = 1'b0;
    logic [TimeW-1:0]    smp_now = '0;
    logic                smp_fix = 1'b0;
    logic                res_ready = 1'b0;
    logic                cfg_we = 1'b0;
    logic [IdxW-1:0]     cfg_index = '0;
    logic [RegW-1:0]     cfg_wdata = '0;

    flq_sample_if smp ();
    flq_result_if rs ();

    assign smp.valid   = smp_valid;
    assign smp.now_ms  = smp_now;
    assign smp.has_fix = smp_fix;
    assign rs.ready    = res_ready;

    fix_lock_qualifier_with_blink i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (smp),
        .result    (rs),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    // flow-control knobs, set by the stimulus process
    int unsigned send_idle = 0;
    int unsigned stall_pct = 0;
    int unsigned hold_len = 0;
    int unsigned hold_tag = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;
    int unsigned fails = 0;

    res_t expected_flags[$];

    // predictor copy of the registers and the qualifier state
    logic [TimeW-1:0] ms_reg [NumRegs];
    logic             lk;
    logic [TimeW-1:0] fix_since;
    logic             fix_seen;
    logic [TimeW-1:0] loss_since;
    logic             loss_seen;
    logic [TimeW-1:0] blink_at;
    logic             blink_owed;
    logic [TimeW-1:0] pulse_off;
    logic [TimeW-1:0] notice_at;
    logic             led_on;

    logic [TimeW-1:0] clock_ms;
    logic             fix_now;

    function automatic res_t qualify_sample(input logic [TimeW-1:0] t, input logic f);
        res_t r;
        r = '0;
        r.fix_echo = f;
        if (f)
        begin
            loss_seen = 1'b0;
            if (!lk)
            begin
                if (!fix_seen)
                begin
                    fix_since = t;
                    fix_seen  = 1'b1;
                end
                if (TimeW'(t - fix_since) >= ms_reg[REG_LOCK_HOLD])
                begin
                    lk            = 1'b1;
                    fix_seen      = 1'b0;
                    r.lock_gained = 1'b1;
                end
            end
            else
            begin
                fix_seen = 1'b0;
            end
        end
        else
        begin
            fix_seen = 1'b0;
            if (!loss_seen)
            begin
                loss_since = t;
                loss_seen  = 1'b1;
            end
            if (lk && TimeW'(t - loss_since) >= ms_reg[REG_UNLOCK_HOLD])
            begin
                lk             = 1'b0;
                blink_owed     = 1'b1;
                pulse_off      = '0;
                r.lock_dropped = 1'b1;
            end
        end

        if (lk)
        begin
            led_on = 1'b1;
        end
        else if (blink_owed || TimeW'(t - blink_at) >= ms_reg[REG_BLINK_INTERVAL])
        begin
            blink_owed = 1'b0;
            blink_at   = t;
            pulse_off  = t + ms_reg[REG_BLINK_PULSE];
            led_on     = 1'b1;
        end
        else if (t >= pulse_off)
        begin
            // absolute compare: a wrapped pulse end turns the LED off at once
            led_on = 1'b0;
        end

        if (!f && TimeW'(t - notice_at) >= ms_reg[REG_NOTICE_INTERVAL])
        begin
            notice_at       = t;
            r.no_fix_notice = 1'b1;
        end

        r.led_level = led_on;
        r.locked    = lk;
        return r;
    endfunction

    function automatic bringup_row_t row_smp(input logic [TimeW-1:0] t, input logic f);
        bringup_row_t r;
        r       = '0;
        r.kind  = ROW_SAMPLE;
        r.t     = t;
        r.fix   = f;
        return r;
    endfunction

    function automatic bringup_row_t row_chk(input logic [TimeW-1:0] t, input logic f,
                                             input res_t want);
        bringup_row_t r;
        r       = row_smp(t, f);
        r.typed = 1'b1;
        r.want  = want;
        return r;
    endfunction

    function automatic bringup_row_t row_reg(input logic [IdxW-1:0] idx,
                                             input logic [RegW-1:0] val);
        bringup_row_t r;
        r      = '0;
        r.kind = ROW_REG;
        r.idx  = idx;
        r.val  = val;
        return r;
    endfunction

    function automatic void check_flag(input string name, input logic want, input logic got);
        if (want !== got)
        begin
            $error("%s: expected %0b, got %0b", name, want, got);
            fails++;
        end
    endfunction

    // result side: ready pattern, with a long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            res_ready <= 1'b0;
        end
        else if (hold_tag != hold_seen)
        begin
            hold_seen <= hold_tag;
            hold_left <= hold_len - 1;
            res_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            res_ready <= 1'b0;
        end
        else
        begin
            res_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        res_t got;
        res_t want;
        if (rst_n && rs.valid && res_ready)
        begin
            got = {rs.led_level, rs.locked, rs.lock_gained, rs.lock_dropped,
                   rs.no_fix_notice, rs.fix_echo};
            if (expected_flags.size() == 0)
            begin
                $error("result item with nothing pending: %b", got);
                fails++;
            end
            else
            begin
                want = expected_flags.pop_front();
                check_flag("led_level", want.led_level, got.led_level);
                check_flag("locked", want.locked, got.locked);
                check_flag("lock_gained", want.lock_gained, got.lock_gained);
                check_flag("lock_dropped", want.lock_dropped, got.lock_dropped);
                check_flag("no_fix_notice", want.no_fix_notice, got.no_fix_notice);
                check_flag("fix_echo", want.fix_echo, got.fix_echo);
            end
        end
    end

    // called at a rising edge; returns at the edge where the item was taken
    task automatic send_sample(input logic [TimeW-1:0] t, input logic f,
                               input logic typed, input res_t want);
        res_t pred;
        while ($urandom_range(0, 99) < send_idle)
        begin
            smp_valid <= 1'b0;
            @(posedge clk);
        end
        smp_valid <= 1'b1;
        smp_now   <= t;
        smp_fix   <= f;
        @(posedge clk);
        while (!smp.ready)
        begin
            @(posedge clk);
        end
        pred = qualify_sample(t, f);
        expected_flags.push_back(typed ? want : pred);
    endtask

    task automatic wait_results_done();
        smp_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (expected_flags.size() != 0);
    endtask

    // leaves cfg_we high; the caller lowers it
    task automatic write_reg(input logic [IdxW-1:0] idx, input logic [RegW-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        if (idx < NumRegs)
        begin
            ms_reg[idx] = TimeW'(val);
        end
    endtask

    task automatic load_regs(input cfg_mode_e mode);
        logic [RegW-1:0] v;
        int unsigned     pick;
        for (int i = 0; i < NumRegs; i++)
        begin
            pick = $urandom_range(0, 9);
            if (mode == CFG_ZERO || (mode == CFG_RANDOM && pick == 0))
            begin
                v = '0;
            end
            else if (mode == CFG_MAX || pick == 1)
            begin
                v = MsMax;
            end
            else
            begin
                v = RegW'($urandom_range(1, 4000));
            end
            write_reg(IdxW'(i), v);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input cfg_mode_e mode, input int n, input int unsigned idle,
                             input int unsigned stall, input int unsigned step_max,
                             input int unsigned hold_cycles);
        logic [TimeW-1:0] t;
        logic             f;
        int unsigned      roll;
        send_idle = 0;
        wait_results_done();
        stall_pct = stall;
        load_regs(mode);
        send_idle = idle;
        if (hold_cycles > 0)
        begin
            hold_len = hold_cycles;
            hold_tag++;
        end
        for (int i = 0; i < n; i++)
        begin
            // mostly monotonic time with fix runs; a few stray timestamps and flags
            roll = $urandom_range(0, 99);
            if (roll < 6)
            begin
                t = $urandom();
            end
            else
            begin
                clock_ms = clock_ms + $urandom_range(0, step_max);
                t = clock_ms;
            end
            if ($urandom_range(0, 5) == 0)
            begin
                fix_now = ~fix_now;
            end
            f = (roll >= 94) ? 1'($urandom_range(0, 1)) : fix_now;
            send_sample(t, f, 1'b0, '0);
            if (i == n / 2 || $urandom_range(0, 59) == 0)
            begin
                wait_results_done();
            end
        end
    endtask

    bringup_row_t bringup_rows[$];

    initial
    begin
        ms_reg[REG_LOCK_HOLD]       = TimeW'(LockHoldRst);
        ms_reg[REG_UNLOCK_HOLD]     = TimeW'(UnlockHoldRst);
        ms_reg[REG_BLINK_INTERVAL]  = TimeW'(BlinkIntervalRst);
        ms_reg[REG_BLINK_PULSE]     = TimeW'(BlinkPulseRst);
        ms_reg[REG_NOTICE_INTERVAL] = TimeW'(NoticeIntervalRst);
        lk         = 1'b0;
        fix_since  = '0;
        fix_seen   = 1'b0;
        loss_since = '0;
        loss_seen  = 1'b0;
        blink_at   = '0;
        blink_owed = 1'b1;
        pulse_off  = '0;
        notice_at  = '0;
        led_on     = 1'b0;
        clock_ms   = 32'd86400400;
        fix_now    = 1'b0;

        // want bits: led locked gained dropped notice echo
        bringup_rows = '{
            row_chk(32'd0, 1'b0, 6'b1_0_0_0_0_0),       // first sample after reset pulses
            row_chk(32'd50, 1'b0, 6'b1_0_0_0_0_0),
            row_chk(32'd100, 1'b0, 6'b0_0_0_0_0_0),     // pulse over
            row_chk(32'd10000, 1'b0, 6'b1_0_0_0_1_0),   // next blink, first notice
            row_smp(32'd10001, 1'b1),
            row_chk(32'd13001, 1'b1, 6'b1_1_1_0_0_1),   // lock after the hold time
            row_smp(32'd13002, 1'b0),
            row_chk(32'd23002, 1'b0, 6'b1_0_0_1_1_0),   // drop, pulse on the same sample
            row_smp(32'd23050, 1'b0),
            row_smp(32'hFFFF_FFC0, 1'b0),               // pulse end wraps
            row_smp(32'hFFFF_FFC1, 1'b0),
            row_smp(32'hFFFF_FFFF, 1'b1),
            row_smp(32'h0000_0BB7, 1'b1),               // hold time across the wrap
            row_reg(REG_LOCK_HOLD, '0),
            row_reg(REG_UNLOCK_HOLD, '0),
            row_reg(REG_BLINK_INTERVAL, '0),
            row_reg(REG_BLINK_PULSE, '0),
            row_reg(REG_NOTICE_INTERVAL, '0),
            row_reg(IdxUnused, 27'h7FF_FFFF),           // ignored index
            row_smp(32'd100, 1'b1),
            row_chk(32'd101, 1'b0, 6'b1_0_0_1_1_0),
            row_chk(32'd102, 1'b0, 6'b1_0_0_0_1_0),
            row_chk(32'd103, 1'b1, 6'b1_1_1_0_0_1),
            row_reg(REG_LOCK_HOLD, MsMax),
            row_reg(REG_UNLOCK_HOLD, MsMax),
            row_reg(REG_BLINK_INTERVAL, MsMax),
            row_reg(REG_BLINK_PULSE, MsMax),
            row_reg(REG_NOTICE_INTERVAL, MsMax),
            row_chk(32'd200, 1'b0, 6'b1_1_0_0_0_0),
            row_chk(32'd86400200, 1'b0, 6'b1_0_0_1_1_0),
            row_smp(32'd86400300, 1'b0)
        };

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (bringup_rows[k])
        begin
            if (bringup_rows[k].kind == ROW_REG)
            begin
                wait_results_done();
                write_reg(bringup_rows[k].idx, bringup_rows[k].val);
                cfg_we <= 1'b0;
            end
            else
            begin
                send_sample(bringup_rows[k].t, bringup_rows[k].fix,
                            bringup_rows[k].typed, bringup_rows[k].want);
            end
        end

        run_phase(CFG_RANDOM, 90, 0, 0, 1500, 0);
        run_phase(CFG_RANDOM, 80, 70, 0, 1500, 0);
        run_phase(CFG_RANDOM, 80, 0, 70, 1500, 0);
        run_phase(CFG_RANDOM, 80, 36, 36, 1500, 0);
        run_phase(CFG_ZERO, 50, 36, 36, 50, 0);
        run_phase(CFG_MAX, 60, 0, 70, 60000000, 0);
        // result side held off while samples keep coming
        run_phase(CFG_RANDOM, 60, 0, 0, 1500, 300);

        wait_results_done();
        repeat (4) @(posedge clk);
        if (fails == 0)
        begin
            $display("fix_lock_qualifier_with_blink: match");
        end
        else
        begin
            $display("fix_lock_qualifier_with_blink: mismatch");
        end
        $finish;
    end

    initial
    begin
        #2000000;
        $display("fix_lock_qualifier_with_blink: mismatch");
        $finish;
    end

endmodule
